FILE: src/tga_rle_pkg.sv
// Shared types, constants and helpers for the TGA RLE pixel decoder.
`timescale 1ns / 1ps
package tga_rle_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  localparam int unsigned DimW     = 13;  // width of size registers
  localparam int unsigned CoordW   = 12;  // row and column
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned QDepth   = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RLE_ENABLE   = 4'd0,
    CFG_PIXEL_FORMAT = 4'd1,
    CFG_IMAGE_WIDTH  = 4'd2,
    CFG_IMAGE_HEIGHT = 4'd3
  } cfg_idx_e;

  // Pixel formats; codes five to seven decode like bgr24
  typedef enum logic [2:0] {
    FMT_GRAY8    = 3'd0,
    FMT_RGB332   = 3'd1,
    FMT_ARGB1555 = 3'd2,
    FMT_BGR24    = 3'd3,
    FMT_BGRA32   = 3'd4
  } fmt_e;

  // One run of identical pixels handed from the front to the back
  typedef struct packed {
    logic [7:0] count;   // 1..128
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } run_t;

  // Live configuration seen by the datapath
  typedef struct packed {
    logic            rle;
    logic [2:0]      fmt;
    logic [DimW-1:0] width;   // clamped
  } cfg_t;

  localparam logic [DimW-1:0] MinWidthC  = DimW'(8);
  localparam logic [DimW-1:0] MaxWidthC  = DimW'(MaxWidth);
  localparam logic [DimW-1:0] MaxHeightC = DimW'(MaxHeight);

  function automatic logic [DimW-1:0] clamp_width(input logic [DimW-1:0] w);
    logic [DimW-1:0] r;
    r = w;
    if (w < MinWidthC) r = MinWidthC;
    if (w > MaxWidthC) r = MaxWidthC;
    return r;
  endfunction

  function automatic logic [DimW-1:0] clamp_height(input logic [DimW-1:0] h);
    logic [DimW-1:0] r;
    r = h;
    if (h == '0) r = DimW'(1);
    if (h > MaxHeightC) r = MaxHeightC;
    return r;
  endfunction

endpackage

FILE: src/tga_rle_if.sv
// Valid/ready channel interfaces for input bytes and output spans.
`timescale 1ns / 1ps
interface tga_rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tga_rle_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] row;
  logic [11:0] column;
  logic [7:0]  span_length;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [7:0]  alpha;
  logic        final_span;
  logic        image_done;

  modport source (output valid, output row, output column, output span_length,
                  output blue, output green, output red, output alpha,
                  output final_span, output image_done, input ready);
  modport sink (input valid, input row, input column, input span_length,
                input blue, input green, input red, input alpha,
                input final_span, input image_done, output ready);
endinterface

FILE: src/tga_rle_queue.sv
// Small run queue between the byte front end and the span back end.
`timescale 1ns / 1ps
module tga_rle_queue
  import tga_rle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic flush_i,
  input  logic push_i,
  input  run_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output run_t pop_data_o
);

  run_t       mem_q [QDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (flush_i) begin
      wr_ptr_d = 1'b0;
      rd_ptr_d = 1'b0;
      cnt_d    = '0;
    end else begin
      if (push_i) wr_ptr_d = ~wr_ptr_q;
      if (pop_i)  rd_ptr_d = ~rd_ptr_q;
      if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
      if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i && !flush_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: src/tga_rle_front.sv
// Front end: packet headers, pixel assembly and color conversion into runs.
`timescale 1ns / 1ps
module tga_rle_front
  import tga_rle_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          restart_i,
  input  logic          rle_next_i,
  tga_rle_in_if.sink    in_byte,
  input  logic          q_full_i,
  output logic          push_o,
  output run_t          push_data_o
);

  logic        expect_hdr_q, expect_hdr_d;
  logic        repeat_q, repeat_d;
  logic [7:0]  remaining_q, remaining_d;
  logic [31:0] pix_q, pix_d;
  logic [1:0]  byte_idx_q, byte_idx_d;

  logic        accept;
  logic        is_header;
  logic [1:0]  last_idx;
  logic        pix_done;
  logic [31:0] pix_asm;
  logic [7:0]  b0, b1, b2, b3;

  assign in_byte.ready = !q_full_i && !restart_i;
  assign accept        = in_byte.valid && in_byte.ready;
  assign is_header     = cfg_i.rle && expect_hdr_q;

  // Index of the last byte of a pixel
  always_comb begin
    unique case (cfg_i.fmt)
      FMT_GRAY8, FMT_RGB332: last_idx = 2'd0;
      FMT_ARGB1555:          last_idx = 2'd1;
      FMT_BGRA32:            last_idx = 2'd3;
      default:               last_idx = 2'd2;
    endcase
  end

  assign pix_done = !is_header && (byte_idx_q == last_idx);

  // Assembled pixel with the incoming byte in place
  always_comb begin
    pix_asm = pix_q;
    pix_asm[8*byte_idx_q +: 8] = in_byte.data_byte;
  end

  assign b0 = pix_asm[7:0];
  assign b1 = pix_asm[15:8];
  assign b2 = pix_asm[23:16];
  assign b3 = pix_asm[31:24];

  // Color conversion to 8-bit B, G, R, A
  always_comb begin
    push_data_o.count = (cfg_i.rle && repeat_q) ? remaining_q : 8'd1;
    unique case (cfg_i.fmt)
      FMT_GRAY8: begin
        push_data_o.blue  = b0;
        push_data_o.green = b0;
        push_data_o.red   = b0;
        push_data_o.alpha = 8'hff;
      end
      FMT_RGB332: begin
        push_data_o.red   = b0 & 8'he0;
        push_data_o.green = {b0[4:2], 5'd0};
        push_data_o.blue  = {b0[1:0], 6'd0};
        push_data_o.alpha = 8'hff;
      end
      FMT_ARGB1555: begin
        push_data_o.red   = {b1[6:2], 3'd0};
        push_data_o.green = {b1[1:0], b0[7:5], 3'd0};
        push_data_o.blue  = {b0[4:0], 3'd0};
        push_data_o.alpha = b1 & 8'h80;
      end
      FMT_BGRA32: begin
        push_data_o.blue  = b0;
        push_data_o.green = b1;
        push_data_o.red   = b2;
        push_data_o.alpha = b3;
      end
      default: begin
        push_data_o.blue  = b0;
        push_data_o.green = b1;
        push_data_o.red   = b2;
        push_data_o.alpha = 8'hff;
      end
    endcase
  end

  assign push_o = accept && pix_done;

  // Packet and pixel assembly state
  always_comb begin
    expect_hdr_d = expect_hdr_q;
    repeat_d     = repeat_q;
    remaining_d  = remaining_q;
    pix_d        = pix_q;
    byte_idx_d   = byte_idx_q;
    if (restart_i) begin
      expect_hdr_d = rle_next_i;
      repeat_d     = 1'b0;
      remaining_d  = '0;
      pix_d        = '0;
      byte_idx_d   = '0;
    end else if (accept) begin
      if (is_header) begin
        repeat_d     = in_byte.data_byte[7];
        remaining_d  = {1'b0, in_byte.data_byte[6:0]} + 8'd1;
        expect_hdr_d = 1'b0;
        byte_idx_d   = '0;
        pix_d        = '0;
      end else if (!pix_done) begin
        pix_d      = pix_asm;
        byte_idx_d = byte_idx_q + 2'd1;
      end else begin
        pix_d      = pix_asm;
        byte_idx_d = '0;
        if (cfg_i.rle) begin
          if (repeat_q) begin
            remaining_d = '0;
          end else if (remaining_q != '0) begin
            remaining_d = remaining_q - 8'd1;
          end
          if (repeat_q || remaining_q <= 8'd1) expect_hdr_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b0;
      repeat_q     <= 1'b0;
      remaining_q  <= '0;
      pix_q        <= '0;
      byte_idx_q   <= '0;
    end else begin
      expect_hdr_q <= expect_hdr_d;
      repeat_q     <= repeat_d;
      remaining_q  <= remaining_d;
      pix_q        <= pix_d;
      byte_idx_q   <= byte_idx_d;
    end
  end

endmodule

FILE: src/tga_rle_back.sv
// Back end: splits runs into row spans, walks rows bottom-up, output register.
`timescale 1ns / 1ps
module tga_rle_back
  import tga_rle_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DimW-1:0]   width_i,
  input  logic              restart_i,
  input  logic [CoordW-1:0] row_init_i,
  input  logic              q_valid_i,
  input  run_t              q_data_i,
  output logic              pop_o,
  tga_rle_out_if.source     out_span
);

  logic              run_valid_q, run_valid_d;
  run_t              run_q, run_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [CoordW-1:0] col_q, col_d;
  logic              finished_q, finished_d;
  logic              out_valid_q, out_valid_d;

  logic [CoordW-1:0] o_row_q, o_col_q;
  logic [7:0]        o_len_q;
  logic [7:0]        o_blue_q, o_green_q, o_red_q, o_alpha_q;
  logic              o_final_q, o_done_q;

  logic              out_free;
  logic              advance;
  logic [DimW-1:0]   avail;
  logic [7:0]        len;
  logic [DimW-1:0]   col_sum;
  logic              row_end;
  logic              img_done;
  logic [7:0]        count_left;

  assign out_free = !out_valid_q || out_span.ready;
  assign advance  = run_valid_q && out_free && !finished_q;
  assign pop_o    = q_valid_i && !run_valid_q && !restart_i;

  // Span length: the rest of the run or the rest of the row
  assign avail      = width_i - {1'b0, col_q};
  assign len        = ({5'd0, run_q.count} < avail) ? run_q.count : avail[7:0];
  assign col_sum    = {1'b0, col_q} + {5'd0, len};
  assign row_end    = (col_sum >= width_i);
  assign img_done   = row_end && (row_q == '0);
  assign count_left = run_q.count - len;

  always_comb begin
    run_valid_d = run_valid_q;
    run_d       = run_q;
    row_d       = row_q;
    col_d       = col_q;
    finished_d  = finished_q;
    out_valid_d = out_valid_q && !out_span.ready;
    if (restart_i) begin
      run_valid_d = 1'b0;
      row_d       = row_init_i;
      col_d       = '0;
      finished_d  = 1'b0;
    end else if (pop_o) begin
      run_valid_d = 1'b1;
      run_d       = q_data_i;
    end else if (run_valid_q && finished_q) begin
      // image already complete: the run is dropped
      run_valid_d = 1'b0;
    end else if (advance) begin
      out_valid_d = 1'b1;
      run_d.count = count_left;
      run_valid_d = (count_left != '0) && !img_done;
      if (row_end) begin
        col_d = '0;
        if (row_q == '0) finished_d = 1'b1;
        else             row_d = row_q - CoordW'(1);
      end else begin
        col_d = col_sum[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      run_valid_q <= run_valid_d;
      row_q       <= row_d;
      col_q       <= col_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Run payload and output fields, no reset
  always_ff @(posedge clk_i) begin
    run_q <= run_d;
    if (advance) begin
      o_row_q   <= row_q;
      o_col_q   <= col_q;
      o_len_q   <= len;
      o_blue_q  <= run_q.blue;
      o_green_q <= run_q.green;
      o_red_q   <= run_q.red;
      o_alpha_q <= run_q.alpha;
      o_final_q <= (count_left == '0) || img_done;
      o_done_q  <= img_done;
    end
  end

  assign out_span.valid       = out_valid_q;
  assign out_span.row         = o_row_q;
  assign out_span.column      = o_col_q;
  assign out_span.span_length = o_len_q;
  assign out_span.blue        = o_blue_q;
  assign out_span.green       = o_green_q;
  assign out_span.red         = o_red_q;
  assign out_span.alpha       = o_alpha_q;
  assign out_span.final_span  = o_final_q;
  assign out_span.image_done  = o_done_q;

  // Checks
  logic [DimW-1:0] o_end;
  assign o_end = {1'b0, o_col_q} + {5'd0, o_len_q};

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (o_len_q != '0) && (o_len_q <= 8'd128))
    else $error("span length out of range");

  a_span_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (o_end <= width_i))
    else $error("span crosses row end");

  a_done_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_done_q) |-> o_final_q)
    else $error("image done on a span that is not final");

  a_no_span_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finished_q && !restart_i) |=> !$rose(out_valid_q))
    else $error("span issued after image completion");

endmodule

FILE: src/tga_rle_pixel_decoder_core.sv
// Top level of the TGA RLE pixel decoder: configuration registers and wiring.
//
// Usage: pixel-data bytes (packet headers included) enter one per handshake
// on in_byte; span writes (row, column, length, B/G/R/A color) leave on
// out_span. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle; any write to a known register restarts the image.
// The first span of a byte that completes a pixel passes through the queue
// write, the run load and the output register before it is valid.
// Throughput: one byte per cycle while the run queue is not full; the back
// end span splitter loads each run and then issues one span per row piece of
// it. The two-entry run queue lets the front take bytes while the back end
// emits; the input stalls when the queue is full.
// After reset: raw mode, bgr24, 8 x 1 image; the first span goes to row
// height-1. When the receiver stalls, the output register holds its span,
// the back end stops, the queue fills and then in_byte.ready falls.
// After the last pixel of the image, bytes are taken and ignored.
`timescale 1ns / 1ps
module tga_rle_pixel_decoder_core
  import tga_rle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  tga_rle_in_if.sink          in_byte,
  tga_rle_out_if.source       out_span,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic            rle_q, rle_d;
  logic [2:0]      fmt_q, fmt_d;
  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic            restart;
  logic [DimW-1:0] height_used;
  cfg_t            cfg;

  logic q_full, q_push, q_pop, q_valid;
  run_t q_in, q_out;

  // Register writes; a known index restarts the image with the new values
  always_comb begin
    rle_d    = rle_q;
    fmt_d    = fmt_q;
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RLE_ENABLE: begin
          rle_d   = cfg_data_i[0];
          restart = 1'b1;
        end
        CFG_PIXEL_FORMAT: begin
          fmt_d   = cfg_data_i[2:0];
          restart = 1'b1;
        end
        CFG_IMAGE_WIDTH: begin
          width_d = cfg_data_i;
          restart = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          height_d = cfg_data_i;
          restart  = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_q    <= 1'b0;
      fmt_q    <= FMT_BGR24;
      width_q  <= DimW'(8);
      height_q <= DimW'(1);
    end else begin
      rle_q    <= rle_d;
      fmt_q    <= fmt_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign height_used = clamp_height(height_d);
  assign cfg.rle     = rle_q;
  assign cfg.fmt     = fmt_q;
  assign cfg.width   = clamp_width(width_q);

  tga_rle_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .restart_i   (restart),
    .rle_next_i  (rle_d),
    .in_byte     (in_byte),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_in)
  );

  tga_rle_queue u_queue (
    .clk_i,
    .rst_ni,
    .flush_i     (restart),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  tga_rle_back u_back (
    .clk_i,
    .rst_ni,
    .width_i    (cfg.width),
    .restart_i  (restart),
    .row_init_i (CoordW'(height_used - DimW'(1))),
    .q_valid_i  (q_valid),
    .q_data_i   (q_out),
    .pop_o      (q_pop),
    .out_span   (out_span)
  );

endmodule
